// ----- src/wsfe_pkg.sv -----
// Shared types, constants and helper functions of the wheel speed command front end.
package wsfe_pkg;

	localparam int KEY_NUMBER  = 6;
	localparam int MILLI_SCALE = 1000;

	localparam int CMD_W     = 12;
	localparam int CPR_W     = 12;
	localparam int STEP_W    = 10;
	localparam int DEB_W     = 3;
	localparam int PPS_W     = 14;
	localparam int SPEED_W   = 16;
	localparam int AVG_W     = 15;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 12;

	localparam int PPS_LIMIT = (2 ** PPS_W) - 1;

	localparam int PROD_W      = CMD_W + CPR_W;
	localparam int RECIP_SHIFT = PROD_W + $clog2(MILLI_SCALE);
	localparam int RECIP_W     = PROD_W + 2;
	localparam int WIDE_W      = PROD_W + RECIP_W;
	localparam int QUOT_W      = WIDE_W - RECIP_SHIFT;
	localparam longint unsigned RECIP_MULT =
		((64'd1 << RECIP_SHIFT) + MILLI_SCALE - 1) / MILLI_SCALE;

	localparam logic [CPR_W-1:0]  CPR_RESET          = CPR_W'(500);
	localparam logic [STEP_W-1:0] RAMP_STEP_RESET    = STEP_W'(50);
	localparam logic [STEP_W-1:0] COMMAND_STEP_RESET = STEP_W'(200);
	localparam logic [CMD_W-1:0]  COMMAND_MIN_RESET  = CMD_W'(200);
	localparam logic [CMD_W-1:0]  COMMAND_MAX_RESET  = CMD_W'(3000);
	localparam logic [DEB_W-1:0]  DEBOUNCE_RESET     = DEB_W'(3);
	localparam logic [CMD_W-1:0]  COMMAND_RESET      = CMD_W'(800);
	localparam logic [DEB_W-1:0]  COUNT_RESET        = DEB_W'(3);
	localparam logic [DEB_W-1:0]  COUNT_ONE          = DEB_W'(1);

	localparam int KEY_START   = 0;
	localparam int KEY_RAISE   = 1;
	localparam int KEY_LOWER   = 2;
	localparam int KEY_STOP    = 3;
	localparam int KEY_REVERSE = 4;
	localparam int KEY_RESET   = 5;

	localparam logic FUNC_POLL = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COUNTS_PER_REV = 3'd0,
		CFG_RAMP_STEP      = 3'd1,
		CFG_COMMAND_STEP   = 3'd2,
		CFG_COMMAND_MIN    = 3'd3,
		CFG_COMMAND_MAX    = 3'd4,
		CFG_DEBOUNCE       = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic                      func;
		logic [KEY_NUMBER-1:0]     key_levels;
		logic signed [SPEED_W-1:0] left_speed;
		logic signed [SPEED_W-1:0] right_speed;
	} req_t;

	typedef struct packed {
		logic             running;
		logic             forward;
		logic [CMD_W-1:0] command_milli_rps;
		logic [PPS_W-1:0] target_pps;
		logic [AVG_W-1:0] left_filtered;
		logic [AVG_W-1:0] right_filtered;
		logic             controllers_reset;
		logic             drive_active;
	} rsp_t;

	typedef struct packed {
		logic [CPR_W-1:0]  counts_per_rev;
		logic [STEP_W-1:0] ramp_step;
		logic [STEP_W-1:0] command_step;
		logic [CMD_W-1:0]  command_min;
		logic [CMD_W-1:0]  command_max;
		logic [DEB_W-1:0]  debounce_samples;
	} cfg_t;

	typedef struct packed {
		logic             running;
		logic             forward;
		logic [CMD_W-1:0] command;
		logic             cleared;
	} key_result_t;

	// Steps the command up or down and clamps it, lower bound checked first.
	function automatic logic [CMD_W-1:0] clamp_command(
		input logic [CMD_W-1:0]  cmd,
		input logic [STEP_W-1:0] step,
		input logic              up,
		input logic [CMD_W-1:0]  lo,
		input logic [CMD_W-1:0]  hi
	);
		logic signed [CMD_W+1:0] v;
		logic [CMD_W-1:0]        r;
		if (up) begin
			v = $signed({2'b00, cmd}) + $signed((CMD_W+2)'(step));
		end else begin
			v = $signed({2'b00, cmd}) - $signed((CMD_W+2)'(step));
		end
		if (v < $signed({2'b00, lo})) begin
			r = lo;
		end else if (v > $signed({2'b00, hi})) begin
			r = hi;
		end else begin
			r = v[CMD_W-1:0];
		end
		return r;
	endfunction

	// Divides the product by the milli scale through a reciprocal and saturates.
	function automatic logic [PPS_W-1:0] to_pps(input logic [PROD_W-1:0] prod);
		logic [WIDE_W-1:0] wide;
		logic [QUOT_W-1:0] quot;
		logic [PPS_W-1:0]  r;
		wide = WIDE_W'(prod) * WIDE_W'(RECIP_MULT);
		quot = wide[WIDE_W-1:RECIP_SHIFT];
		if (quot > QUOT_W'(PPS_LIMIT)) begin
			r = PPS_W'(PPS_LIMIT);
		end else begin
			r = quot[PPS_W-1:0];
		end
		return r;
	endfunction

	// Quarter-step filter on the speed magnitude, with the quotient truncated toward zero.
	function automatic logic [AVG_W-1:0] quarter_filter(
		input logic [AVG_W-1:0]          avg,
		input logic signed [SPEED_W-1:0] speed
	);
		logic signed [SPEED_W+1:0] mag;
		logic signed [SPEED_W+1:0] diff;
		logic signed [SPEED_W+1:0] quarter;
		logic signed [SPEED_W+1:0] sum;
		mag = (SPEED_W+2)'(speed);
		if (mag < 0) begin
			mag = -mag;
		end
		diff = mag - $signed((SPEED_W+2)'(avg));
		if (diff < 0) begin
			quarter = -((-diff) >>> 2);
		end else begin
			quarter = diff >>> 2;
		end
		sum = $signed((SPEED_W+2)'(avg)) + quarter;
		return sum[AVG_W-1:0];
	endfunction

endpackage

// ----- src/wheel_speed_command_front_end.sv -----
// Top level of the wheel speed command front end: pipeline, speed conversion, ramp and filters.
//
// One request is taken per clock cycle while the pipeline is not held, and its result moves
// stage by stage to the output register. The pipeline has three stages ahead of the result
// register: the first runs key debounce and key actions and forms the product of the speed
// command and the counts per revolution, the second divides that product by the milli
// scale with a reciprocal multiply, and the third runs the ramp and the speed filters. Each
// stage holds its request while the next one is full, so a result waiting in the output
// register does not stop new requests until all stages are occupied. Configuration writes
// are taken in every cycle and must only be issued while no request is in flight.
module wheel_speed_command_front_end (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  wsfe_pkg::req_t                   req_data,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output wsfe_pkg::rsp_t                   rsp_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [wsfe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wsfe_pkg::CFG_DAT_W-1:0]   cfg_data
);

	wsfe_pkg::cfg_t cfg_q;

	logic go_out;
	logic go3;
	logic go2;
	logic go1;

	logic                  valid_s1;
	wsfe_pkg::req_t        req_s1;
	wsfe_pkg::key_result_t key_res;
	logic                  sample;
	logic                  commit;
	logic [wsfe_pkg::PROD_W-1:0] prod_cmd;
	logic [wsfe_pkg::PROD_W-1:0] prod_max;

	logic                              valid_s2;
	logic                              tick_s2;
	logic signed [wsfe_pkg::SPEED_W-1:0] left_s2;
	logic signed [wsfe_pkg::SPEED_W-1:0] right_s2;
	wsfe_pkg::key_result_t             key_res_s2;
	logic [wsfe_pkg::PROD_W-1:0]       prod_cmd_s2;
	logic [wsfe_pkg::PROD_W-1:0]       prod_max_s2;

	logic                              valid_s3;
	logic                              tick_s3;
	logic signed [wsfe_pkg::SPEED_W-1:0] left_s3;
	logic signed [wsfe_pkg::SPEED_W-1:0] right_s3;
	wsfe_pkg::key_result_t             key_res_s3;
	logic [wsfe_pkg::PPS_W-1:0]        cmd_pps_s3;
	logic [wsfe_pkg::PPS_W-1:0]        ceil_pps_s3;

	logic [wsfe_pkg::PPS_W-1:0] ramp_q;
	logic [wsfe_pkg::AVG_W-1:0] left_avg_q;
	logic [wsfe_pkg::AVG_W-1:0] right_avg_q;
	logic [wsfe_pkg::PPS_W-1:0] ramp_d;
	logic [wsfe_pkg::AVG_W-1:0] left_avg_d;
	logic [wsfe_pkg::AVG_W-1:0] right_avg_d;

	logic signed [wsfe_pkg::PPS_W+1:0] t_w;
	logic signed [wsfe_pkg::PPS_W+1:0] c_w;
	logic signed [wsfe_pkg::PPS_W+1:0] ceil_w;
	logic signed [wsfe_pkg::PPS_W+1:0] up_w;
	logic signed [wsfe_pkg::PPS_W+1:0] dn_w;

	logic           rsp_valid_q;
	wsfe_pkg::rsp_t rsp_q;
	wsfe_pkg::rsp_t rsp_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.counts_per_rev   <= wsfe_pkg::CPR_RESET;
			cfg_q.ramp_step        <= wsfe_pkg::RAMP_STEP_RESET;
			cfg_q.command_step     <= wsfe_pkg::COMMAND_STEP_RESET;
			cfg_q.command_min      <= wsfe_pkg::COMMAND_MIN_RESET;
			cfg_q.command_max      <= wsfe_pkg::COMMAND_MAX_RESET;
			cfg_q.debounce_samples <= wsfe_pkg::DEBOUNCE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				wsfe_pkg::CFG_COUNTS_PER_REV: begin
					cfg_q.counts_per_rev <= cfg_data[wsfe_pkg::CPR_W-1:0];
				end
				wsfe_pkg::CFG_RAMP_STEP: begin
					cfg_q.ramp_step <= cfg_data[wsfe_pkg::STEP_W-1:0];
				end
				wsfe_pkg::CFG_COMMAND_STEP: begin
					cfg_q.command_step <= cfg_data[wsfe_pkg::STEP_W-1:0];
				end
				wsfe_pkg::CFG_COMMAND_MIN: begin
					cfg_q.command_min <= cfg_data[wsfe_pkg::CMD_W-1:0];
				end
				wsfe_pkg::CFG_COMMAND_MAX: begin
					cfg_q.command_max <= cfg_data[wsfe_pkg::CMD_W-1:0];
				end
				wsfe_pkg::CFG_DEBOUNCE: begin
					cfg_q.debounce_samples <= cfg_data[wsfe_pkg::DEB_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign go_out    = !rsp_valid_q || rsp_ready;
	assign go3       = !valid_s3 || go_out;
	assign go2       = !valid_s2 || go3;
	assign go1       = !valid_s1 || go2;
	assign req_ready = go1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (go1) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && go1) begin
			req_s1 <= req_data;
		end
	end

	assign sample = valid_s1 && (req_s1.func == wsfe_pkg::FUNC_POLL);
	assign commit = sample && go2;

	wsfe_keys u_keys (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.keys   (req_s1.key_levels),
		.sample (sample),
		.commit (commit),
		.result (key_res)
	);

	assign prod_cmd = wsfe_pkg::PROD_W'(key_res.command) *
		wsfe_pkg::PROD_W'(cfg_q.counts_per_rev);
	assign prod_max = wsfe_pkg::PROD_W'(cfg_q.command_max) *
		wsfe_pkg::PROD_W'(cfg_q.counts_per_rev);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && go2) begin
			tick_s2     <= (req_s1.func == wsfe_pkg::FUNC_TICK);
			left_s2     <= req_s1.left_speed;
			right_s2    <= req_s1.right_speed;
			key_res_s2  <= key_res;
			prod_cmd_s2 <= prod_cmd;
			prod_max_s2 <= prod_max;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (go3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && go3) begin
			tick_s3     <= tick_s2;
			left_s3     <= left_s2;
			right_s3    <= right_s2;
			key_res_s3  <= key_res_s2;
			cmd_pps_s3  <= wsfe_pkg::to_pps(prod_cmd_s2);
			ceil_pps_s3 <= wsfe_pkg::to_pps(prod_max_s2);
		end
	end

	// Ramp toward the command; going down, the target is held between command and ceiling.
	always_comb begin
		t_w    = $signed((wsfe_pkg::PPS_W+2)'(ramp_q));
		c_w    = $signed((wsfe_pkg::PPS_W+2)'(cmd_pps_s3));
		ceil_w = $signed((wsfe_pkg::PPS_W+2)'(ceil_pps_s3));
		up_w   = t_w + $signed((wsfe_pkg::PPS_W+2)'(cfg_q.ramp_step));
		dn_w   = t_w - $signed((wsfe_pkg::PPS_W+2)'(cfg_q.ramp_step));
		ramp_d      = ramp_q;
		left_avg_d  = left_avg_q;
		right_avg_d = right_avg_q;
		if (tick_s3) begin
			left_avg_d  = wsfe_pkg::quarter_filter(left_avg_q, left_s3);
			right_avg_d = wsfe_pkg::quarter_filter(right_avg_q, right_s3);
			if (key_res_s3.running) begin
				if (t_w < c_w) begin
					ramp_d = (up_w > c_w) ? cmd_pps_s3 : up_w[wsfe_pkg::PPS_W-1:0];
				end else if (t_w > c_w) begin
					if (dn_w < c_w) begin
						ramp_d = cmd_pps_s3;
					end else if (dn_w > ceil_w) begin
						ramp_d = ceil_pps_s3;
					end else begin
						ramp_d = dn_w[wsfe_pkg::PPS_W-1:0];
					end
				end
			end
		end else if (key_res_s3.cleared) begin
			ramp_d = '0;
		end
	end

	always_comb begin
		rsp_d.running           = key_res_s3.running;
		rsp_d.forward           = key_res_s3.forward;
		rsp_d.command_milli_rps = key_res_s3.command;
		rsp_d.target_pps        = ramp_d;
		rsp_d.left_filtered     = left_avg_d;
		rsp_d.right_filtered    = right_avg_d;
		rsp_d.controllers_reset = key_res_s3.cleared;
		rsp_d.drive_active      = tick_s3 && key_res_s3.running;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_q      <= '0;
			left_avg_q  <= '0;
			right_avg_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (valid_s3 && go_out) begin
				ramp_q      <= ramp_d;
				left_avg_q  <= left_avg_d;
				right_avg_q <= right_avg_d;
			end
			if (go_out) begin
				rsp_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && go_out) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	a_drive_only_running: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.drive_active |-> rsp_data.running && !rsp_data.controllers_reset)
		else $error("Drive active without running or together with a controller reset.");

	a_stopped_target_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.running |-> rsp_data.target_pps == '0)
		else $error("Target is not zero while the drive is stopped.");

	a_clear_target_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.controllers_reset |-> rsp_data.target_pps == '0)
		else $error("Controller reset left a nonzero target.");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !go2 |=> valid_s1 && $stable(req_s1))
		else $error("First stage lost or changed a stalled request.");

endmodule

// ----- src/wsfe_keys.sv -----
// Key debounce and key actions on the run flag, direction and speed command.
module wsfe_keys (
	input  logic                             clk,
	input  logic                             arst_n,
	input  wsfe_pkg::cfg_t                   cfg,
	input  logic [wsfe_pkg::KEY_NUMBER-1:0]  keys,
	input  logic                             sample,
	input  logic                             commit,
	output wsfe_pkg::key_result_t            result
);

	logic [wsfe_pkg::KEY_NUMBER-1:0] last_q;
	logic [wsfe_pkg::KEY_NUMBER-1:0] stable_q;
	logic [wsfe_pkg::DEB_W-1:0]      cnt_q [wsfe_pkg::KEY_NUMBER];
	logic [wsfe_pkg::DEB_W-1:0]      cnt_d [wsfe_pkg::KEY_NUMBER];
	logic [wsfe_pkg::KEY_NUMBER-1:0] take;
	logic                            run_q;
	logic                            dir_q;
	logic [wsfe_pkg::CMD_W-1:0]      cmd_q;
	logic                            run_d;
	logic                            dir_d;
	logic [wsfe_pkg::CMD_W-1:0]      cmd_d;
	logic                            cleared;

	always_comb begin
		for (int i = 0; i < wsfe_pkg::KEY_NUMBER; i++) begin
			if (keys[i] != last_q[i]) begin
				cnt_d[i] = wsfe_pkg::COUNT_ONE;
			end else if (cnt_q[i] < cfg.debounce_samples) begin
				cnt_d[i] = cnt_q[i] + wsfe_pkg::COUNT_ONE;
			end else begin
				cnt_d[i] = cnt_q[i];
			end
			take[i] = (keys[i] == last_q[i]) && (cnt_d[i] == cfg.debounce_samples) &&
				(stable_q[i] != keys[i]);
		end
	end

	// Newly stable presses act in key order, so later keys see earlier changes.
	always_comb begin
		run_d   = run_q;
		dir_d   = dir_q;
		cmd_d   = cmd_q;
		cleared = 1'b0;
		for (int k = 0; k < wsfe_pkg::KEY_NUMBER; k++) begin
			if (sample && take[k] && keys[k]) begin
				case (k)
					wsfe_pkg::KEY_START: begin
						run_d   = 1'b1;
						cleared = 1'b1;
					end
					wsfe_pkg::KEY_RAISE: begin
						cmd_d = wsfe_pkg::clamp_command(cmd_d, cfg.command_step, 1'b1,
							cfg.command_min, cfg.command_max);
					end
					wsfe_pkg::KEY_LOWER: begin
						cmd_d = wsfe_pkg::clamp_command(cmd_d, cfg.command_step, 1'b0,
							cfg.command_min, cfg.command_max);
					end
					wsfe_pkg::KEY_STOP: begin
						run_d   = 1'b0;
						cleared = 1'b1;
					end
					wsfe_pkg::KEY_REVERSE: begin
						run_d   = 1'b0;
						dir_d   = ~dir_d;
						cleared = 1'b1;
					end
					wsfe_pkg::KEY_RESET: begin
						cleared = 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign result.running = run_d;
	assign result.forward = dir_d;
	assign result.command = cmd_d;
	assign result.cleared = cleared;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= '0;
			stable_q <= '0;
			for (int i = 0; i < wsfe_pkg::KEY_NUMBER; i++) begin
				cnt_q[i] <= wsfe_pkg::COUNT_RESET;
			end
			run_q <= 1'b0;
			dir_q <= 1'b1;
			cmd_q <= wsfe_pkg::COMMAND_RESET;
		end else if (commit) begin
			last_q <= keys;
			for (int i = 0; i < wsfe_pkg::KEY_NUMBER; i++) begin
				cnt_q[i] <= cnt_d[i];
				if (take[i]) begin
					stable_q[i] <= keys[i];
				end
			end
			run_q <= run_d;
			dir_q <= dir_d;
			cmd_q <= cmd_d;
		end
	end

endmodule

// ----- dv/wheel_speed_command_front_end_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the wheel speed command front end with its own drive model.
module wheel_speed_command_front_end_tb;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           req_valid = 1'b0;
	logic                           req_ready;
	wsfe_pkg::req_t                 req_data  = '0;
	logic                           rsp_valid;
	logic                           rsp_ready = 1'b0;
	wsfe_pkg::rsp_t                 rsp_data;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [wsfe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [wsfe_pkg::CFG_DAT_W-1:0] cfg_data  = '0;

	wheel_speed_command_front_end dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	wsfe_pkg::cfg_t             model_cfg;
	logic                       key_last   [wsfe_pkg::KEY_NUMBER];
	logic                       key_stable [wsfe_pkg::KEY_NUMBER];
	logic [wsfe_pkg::DEB_W-1:0] key_streak [wsfe_pkg::KEY_NUMBER];
	logic                       run_now;
	logic                       fwd_now;
	logic [wsfe_pkg::CMD_W-1:0] cmd_now;
	logic [wsfe_pkg::PPS_W-1:0] target_now;
	logic [wsfe_pkg::AVG_W-1:0] left_avg;
	logic [wsfe_pkg::AVG_W-1:0] right_avg;

	wsfe_pkg::rsp_t pending_status [$];
	wsfe_pkg::rsp_t oldest_status;
	int   mismatches      = 0;
	int   results_checked = 0;
	int   poll_count      = 0;
	int   tick_count      = 0;
	int   setting_count   = 0;
	int   burst_left      = 0;
	int   ready_cycle     = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d results still outstanding.", pending_status.size());
		$display("wheel_speed_command_front_end test failed");
		$finish;
	end

	task automatic reset_model();
		model_cfg.counts_per_rev   = wsfe_pkg::CPR_RESET;
		model_cfg.ramp_step        = wsfe_pkg::RAMP_STEP_RESET;
		model_cfg.command_step     = wsfe_pkg::COMMAND_STEP_RESET;
		model_cfg.command_min      = wsfe_pkg::COMMAND_MIN_RESET;
		model_cfg.command_max      = wsfe_pkg::COMMAND_MAX_RESET;
		model_cfg.debounce_samples = wsfe_pkg::DEBOUNCE_RESET;
		for (int k = 0; k < wsfe_pkg::KEY_NUMBER; k++) begin
			key_last[k]   = 1'b0;
			key_stable[k] = 1'b0;
			key_streak[k] = wsfe_pkg::DEB_W'(3);
		end
		run_now    = 1'b0;
		fwd_now    = 1'b1;
		cmd_now    = wsfe_pkg::CMD_W'(800);
		target_now = '0;
		left_avg   = '0;
		right_avg  = '0;
	endtask

	function automatic int limit_to(input int v, input int lo, input int hi);
		if (v < lo) begin
			return lo;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	function automatic int to_pulses(input int unsigned milli);
		int unsigned p;
		p = (milli * model_cfg.counts_per_rev) / wsfe_pkg::MILLI_SCALE;
		return (p > wsfe_pkg::PPS_LIMIT) ? wsfe_pkg::PPS_LIMIT : int'(p);
	endfunction

	function automatic logic [wsfe_pkg::AVG_W-1:0] smooth(
			input logic [wsfe_pkg::AVG_W-1:0] avg,
			input logic signed [wsfe_pkg::SPEED_W-1:0] speed);
		int mag;
		int a;
		mag = speed;
		if (mag < 0) begin
			mag = -mag;
		end
		a = int'(avg);
		return wsfe_pkg::AVG_W'(a + (mag - a) / 4);
	endfunction

	// Applies the action of a newly pressed key and tells whether it cleared the controllers.
	function automatic bit press_key(input int k);
		case (k)
			wsfe_pkg::KEY_START: begin
				target_now = '0;
				run_now = 1'b1;
				return 1'b1;
			end
			wsfe_pkg::KEY_RAISE: begin
				cmd_now = wsfe_pkg::CMD_W'(limit_to(
					int'(cmd_now) + int'(model_cfg.command_step),
					int'(model_cfg.command_min), int'(model_cfg.command_max)));
				return 1'b0;
			end
			wsfe_pkg::KEY_LOWER: begin
				cmd_now = wsfe_pkg::CMD_W'(limit_to(
					int'(cmd_now) - int'(model_cfg.command_step),
					int'(model_cfg.command_min), int'(model_cfg.command_max)));
				return 1'b0;
			end
			wsfe_pkg::KEY_STOP: begin
				run_now = 1'b0;
				target_now = '0;
				return 1'b1;
			end
			wsfe_pkg::KEY_REVERSE: begin
				run_now = 1'b0;
				target_now = '0;
				fwd_now = ~fwd_now;
				return 1'b1;
			end
			wsfe_pkg::KEY_RESET: begin
				target_now = '0;
				return 1'b1;
			end
			default: begin
				return 1'b0;
			end
		endcase
	endfunction

	function automatic wsfe_pkg::rsp_t advance_drive(input wsfe_pkg::req_t item);
		wsfe_pkg::rsp_t o;
		logic lvl;
		logic cleared;
		logic active;
		int   goal;
		cleared = 1'b0;
		active  = 1'b0;
		if (item.func == wsfe_pkg::FUNC_POLL) begin
			for (int k = 0; k < wsfe_pkg::KEY_NUMBER; k++) begin
				lvl = item.key_levels[k];
				if (lvl != key_last[k]) begin
					key_last[k]   = lvl;
					key_streak[k] = wsfe_pkg::DEB_W'(1);
				end else begin
					if (key_streak[k] < model_cfg.debounce_samples) begin
						key_streak[k] = key_streak[k] + 1'b1;
					end
					if (key_streak[k] == model_cfg.debounce_samples &&
							key_stable[k] != lvl) begin
						key_stable[k] = lvl;
						if (lvl && press_key(k)) begin
							cleared = 1'b1;
						end
					end
				end
			end
		end else begin
			goal      = to_pulses(cmd_now);
			left_avg  = smooth(left_avg, item.left_speed);
			right_avg = smooth(right_avg, item.right_speed);
			if (run_now) begin
				active = 1'b1;
				if (int'(target_now) < goal) begin
					target_now = wsfe_pkg::PPS_W'(limit_to(
						int'(target_now) + int'(model_cfg.ramp_step), 0, goal));
				end else if (int'(target_now) > goal) begin
					target_now = wsfe_pkg::PPS_W'(limit_to(
						int'(target_now) - int'(model_cfg.ramp_step),
						goal, to_pulses(model_cfg.command_max)));
				end
			end
		end
		o.running           = run_now;
		o.forward           = fwd_now;
		o.command_milli_rps = cmd_now;
		o.target_pps        = target_now;
		o.left_filtered     = left_avg;
		o.right_filtered    = right_avg;
		o.controllers_reset = cleared;
		o.drive_active      = active;
		return o;
	endfunction

	function automatic logic [wsfe_pkg::KEY_NUMBER-1:0] key_mask(input int k);
		return wsfe_pkg::KEY_NUMBER'(1) << k;
	endfunction

	function automatic logic signed [wsfe_pkg::SPEED_W-1:0] pick_speed();
		case ($urandom_range(15))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh8001;
			3: return 16'sh0000;
			4: return 16'shffff;
			default: return wsfe_pkg::SPEED_W'($urandom);
		endcase
	endfunction

	function automatic wsfe_pkg::req_t make_poll(input logic [wsfe_pkg::KEY_NUMBER-1:0] keys);
		wsfe_pkg::req_t r;
		r.func        = wsfe_pkg::FUNC_POLL;
		r.key_levels  = keys;
		r.left_speed  = wsfe_pkg::SPEED_W'($urandom);
		r.right_speed = wsfe_pkg::SPEED_W'($urandom);
		return r;
	endfunction

	function automatic wsfe_pkg::req_t make_tick(
			input logic signed [wsfe_pkg::SPEED_W-1:0] left,
			input logic signed [wsfe_pkg::SPEED_W-1:0] right);
		wsfe_pkg::req_t r;
		r.func        = wsfe_pkg::FUNC_TICK;
		r.key_levels  = wsfe_pkg::KEY_NUMBER'($urandom);
		r.left_speed  = left;
		r.right_speed = right;
		return r;
	endfunction

	function automatic wsfe_pkg::cfg_t make_setting(input int cpr, input int ramp,
			input int step, input int lo, input int hi, input int deb);
		wsfe_pkg::cfg_t s;
		s.counts_per_rev   = wsfe_pkg::CPR_W'(cpr);
		s.ramp_step        = wsfe_pkg::STEP_W'(ramp);
		s.command_step     = wsfe_pkg::STEP_W'(step);
		s.command_min      = wsfe_pkg::CMD_W'(lo);
		s.command_max      = wsfe_pkg::CMD_W'(hi);
		s.debounce_samples = wsfe_pkg::DEB_W'(deb);
		return s;
	endfunction

	task automatic send_req(input wsfe_pkg::req_t item);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 10);
			if (gap != 0) begin
				if (req_valid) begin
					req_valid <= 1'b0;
				end
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		req_data  <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		pending_status.push_back(advance_drive(item));
		if (item.func == wsfe_pkg::FUNC_POLL) begin
			poll_count++;
		end else begin
			tick_count++;
		end
	endtask

	task automatic wait_quiet();
		if (req_valid) begin
			req_valid <= 1'b0;
		end
		while (pending_status.size() != 0) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_reg(input wsfe_pkg::cfg_index_t idx,
			input logic [wsfe_pkg::CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			wsfe_pkg::CFG_COUNTS_PER_REV:
				model_cfg.counts_per_rev = val[wsfe_pkg::CPR_W-1:0];
			wsfe_pkg::CFG_RAMP_STEP:
				model_cfg.ramp_step = val[wsfe_pkg::STEP_W-1:0];
			wsfe_pkg::CFG_COMMAND_STEP:
				model_cfg.command_step = val[wsfe_pkg::STEP_W-1:0];
			wsfe_pkg::CFG_COMMAND_MIN:
				model_cfg.command_min = val[wsfe_pkg::CMD_W-1:0];
			wsfe_pkg::CFG_COMMAND_MAX:
				model_cfg.command_max = val[wsfe_pkg::CMD_W-1:0];
			wsfe_pkg::CFG_DEBOUNCE:
				model_cfg.debounce_samples = val[wsfe_pkg::DEB_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input wsfe_pkg::cfg_t s);
		write_reg(wsfe_pkg::CFG_COUNTS_PER_REV, wsfe_pkg::CFG_DAT_W'(s.counts_per_rev));
		write_reg(wsfe_pkg::CFG_RAMP_STEP, wsfe_pkg::CFG_DAT_W'(s.ramp_step));
		write_reg(wsfe_pkg::CFG_COMMAND_STEP, wsfe_pkg::CFG_DAT_W'(s.command_step));
		write_reg(wsfe_pkg::CFG_COMMAND_MIN, wsfe_pkg::CFG_DAT_W'(s.command_min));
		write_reg(wsfe_pkg::CFG_COMMAND_MAX, wsfe_pkg::CFG_DAT_W'(s.command_max));
		write_reg(wsfe_pkg::CFG_DEBOUNCE, wsfe_pkg::CFG_DAT_W'(s.debounce_samples));
		cfg_valid <= 1'b0;
		setting_count++;
	endtask

	task automatic compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("Result %0d, %s: expected %0d, got %0d.", results_checked, name,
					want, got);
			end
		end
	endtask

	always @(posedge clk) begin
		ready_cycle++;
		case ((ready_cycle / 173) % 4)
			0: rsp_ready <= 1'b1;
			1: rsp_ready <= ($urandom_range(1) == 0);
			2: rsp_ready <= ($urandom_range(3) == 0);
			default: rsp_ready <= ((ready_cycle % 16) < 8);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Result with no request outstanding: %h.", rsp_data);
				end
			end else begin
				oldest_status = pending_status.pop_front();
				compare_field("running", oldest_status.running, rsp_data.running);
				compare_field("forward", oldest_status.forward, rsp_data.forward);
				compare_field("command_milli_rps", oldest_status.command_milli_rps,
					rsp_data.command_milli_rps);
				compare_field("target_pps", oldest_status.target_pps, rsp_data.target_pps);
				compare_field("left_filtered", oldest_status.left_filtered,
					rsp_data.left_filtered);
				compare_field("right_filtered", oldest_status.right_filtered,
					rsp_data.right_filtered);
				compare_field("controllers_reset", oldest_status.controllers_reset,
					rsp_data.controllers_reset);
				compare_field("drive_active", oldest_status.drive_active,
					rsp_data.drive_active);
				results_checked++;
			end
		end
	end

	task automatic test_key_actions();
		wsfe_pkg::cfg_t s;
		s = model_cfg;
		s.debounce_samples = wsfe_pkg::DEB_W'(1);
		load_settings(s);
		repeat (2) send_req(make_poll(key_mask(wsfe_pkg::KEY_START)));
		send_req(make_tick(16'sh7fff, 16'sh8000));
		send_req(make_tick(16'sh8001, 16'sh0000));
		repeat (2) send_req(make_poll(key_mask(wsfe_pkg::KEY_RAISE)));
		repeat (2) send_req(make_poll(key_mask(wsfe_pkg::KEY_LOWER)));
		repeat (2) send_req(make_poll({wsfe_pkg::KEY_NUMBER{1'b1}}));
		repeat (2) send_req(make_poll('0));
		repeat (2) send_req(make_poll(key_mask(wsfe_pkg::KEY_STOP)));
		repeat (2) send_req(make_poll(key_mask(wsfe_pkg::KEY_REVERSE)));
		repeat (2) send_req(make_poll(key_mask(wsfe_pkg::KEY_RESET)));
		send_req(make_tick(16'sh0000, 16'shffff));
	endtask

	// A key held past its count must not act again after the debounce is lowered.
	task automatic test_debounce_lowering();
		wsfe_pkg::cfg_t s;
		wait_quiet();
		s = model_cfg;
		s.debounce_samples = wsfe_pkg::DEB_W'(4);
		load_settings(s);
		repeat (4) send_req(make_poll(key_mask(wsfe_pkg::KEY_RAISE)));
		wait_quiet();
		s.debounce_samples = wsfe_pkg::DEB_W'(2);
		load_settings(s);
		repeat (2) send_req(make_poll(key_mask(wsfe_pkg::KEY_RAISE)));
	endtask

	task automatic run_traffic(input int count);
		int sent;
		int hold;
		int ticks;
		int r;
		bit paused;
		logic [wsfe_pkg::KEY_NUMBER-1:0] keys;
		sent   = 0;
		paused = 1'b0;
		while (sent < count) begin
			r = $urandom_range(99);
			if (r < 30) begin
				keys = key_mask(wsfe_pkg::KEY_START);
			end else if (r < 42) begin
				keys = key_mask(wsfe_pkg::KEY_RAISE);
			end else if (r < 54) begin
				keys = key_mask(wsfe_pkg::KEY_LOWER);
			end else if (r < 60) begin
				keys = key_mask(wsfe_pkg::KEY_STOP);
			end else if (r < 66) begin
				keys = key_mask(wsfe_pkg::KEY_REVERSE);
			end else if (r < 72) begin
				keys = key_mask(wsfe_pkg::KEY_RESET);
			end else if (r < 86) begin
				keys = '0;
			end else begin
				keys = wsfe_pkg::KEY_NUMBER'($urandom);
			end
			if ($urandom_range(9) == 0) begin
				hold = $urandom_range(1, 2);
			end else begin
				hold = int'(model_cfg.debounce_samples) + $urandom_range(1, 3);
			end
			repeat (hold) begin
				if ($urandom_range(15) == 0) begin
					send_req(make_poll(keys ^
						key_mask($urandom_range(wsfe_pkg::KEY_NUMBER - 1))));
				end else begin
					send_req(make_poll(keys));
				end
				sent++;
			end
			ticks = $urandom_range(0, 10);
			repeat (ticks) begin
				send_req(make_tick(pick_speed(), pick_speed()));
				sent++;
			end
			if (!paused && sent >= count / 2) begin
				wait_quiet();
				paused = 1'b1;
			end
		end
	endtask

	task automatic test_random_settings();
		wsfe_pkg::cfg_t plan;
		for (int n = 0; n < 9; n++) begin
			case (n)
				0: plan = make_setting(500, 50, 200, 200, 3000, 3);
				1: plan = make_setting(4095, 1023, 1000, 0, 4000, 7);
				2: plan = make_setting(1, 1, 0, 0, 0, 1);
				3: plan = make_setting(2000, 300, 700, 3500, 1000, 2);
				4: plan = make_setting(4095, 1023, 1023, 3000, 4095, 2);
				5: plan = make_setting(800, 200, 500, 0, 4000, 0);
				default: plan = make_setting($urandom_range(1, 4095), $urandom_range(1, 1023),
					$urandom_range(0, 1000), $urandom_range(0, 4000), $urandom_range(0, 4000),
					$urandom_range(1, 7));
			endcase
			wait_quiet();
			load_settings(plan);
			run_traffic(165);
		end
	endtask

	initial begin
		reset_model();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_key_actions();
		test_debounce_lowering();
		test_random_settings();
		wait_quiet();
		repeat (10) @(posedge clk);
		$display("Sent %0d key polls and %0d control ticks across %0d register settings.",
			poll_count, tick_count, setting_count);
		$display("Checked %0d results and found %0d field mismatches.", results_checked,
			mismatches);
		if (mismatches == 0 && pending_status.size() == 0) begin
			$display("wheel_speed_command_front_end test passed");
		end else begin
			$display("wheel_speed_command_front_end test failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/wsfe_pkg.sv
src/wsfe_keys.sv
src/wheel_speed_command_front_end.sv
dv/wheel_speed_command_front_end_tb.sv
